// File: rtl/core/rwl_pkg.sv
// Shared types and constants for the readers/writers lock arbiter.
`default_nettype none
package rwl_pkg;

    localparam int unsigned ID_W        = 5;
    localparam int unsigned READERS_W   = 6;
    localparam logic [READERS_W-1:0] READERS_MAX = 6'd63;

    localparam logic ACT_LOCK    = 1'b0;
    localparam logic ACT_UNLOCK  = 1'b1;
    localparam logic KIND_READER = 1'b0;
    localparam logic KIND_WRITER = 1'b1;

    typedef enum logic [1:0] {
        REPLY_GRANT     = 2'd0,
        REPLY_ACK       = 2'd1,
        REPLY_FULL      = 2'd2,
        REPLY_NO_HOLDER = 2'd3
    } rwl_reply_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CHECK
    } rwl_state_t;

    typedef struct packed {
        logic            action;
        logic            requester_kind;
        logic [ID_W-1:0] requester_id;
    } rwl_request_t;

    typedef struct packed {
        logic            target_kind;
        logic [ID_W-1:0] target_id;
        rwl_reply_t      reply_kind;
        logic            last;
    } rwl_result_t;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] id;
    } rwl_entry_t;

    typedef struct packed {
        logic take;
        logic release_hold;
        logic kind;
    } rwl_lock_op_t;

    typedef struct packed {
        logic compatible;
        logic held;
    } rwl_lock_status_t;

endpackage
`default_nettype wire

// File: rtl/core/readers_writers_lock_arbiter_core.sv
// Top level of the FIFO-fair readers/writers lock arbiter.
// A request runs through the exec, head read and check states; each waiter
// drained from the queue adds another head read and check.
// Busy stays high until the drain ends; the last reply is strobed in the
// first cycle busy is low again.
// Reset clears the counts, pointers and sequencer; queue memory is not cleared.
`default_nettype none
module readers_writers_lock_arbiter_core
    import rwl_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH  = 32,
    parameter int unsigned CLIENT_COUNT = 32
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire rwl_request_t request,
    output logic              busy,
    output logic              result_valid,
    output rwl_result_t       result
);

    localparam int unsigned AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned FW    = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned CMP_W = 9;

    // ------------------------------------------------------------------
    // Sequencer state and datapath registers
    // ------------------------------------------------------------------
    rwl_state_t       state_reg;
    rwl_state_t       state_next;
    rwl_request_t     req_reg;
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    head_next;
    logic [AW-1:0]    tail_reg;
    logic [AW-1:0]    tail_next;
    logic [FW-1:0]    fill_reg;
    logic [FW-1:0]    fill_next;
    // pending reply: held back one step so its last flag is known when sent
    logic             pend_valid_reg;
    logic             pend_valid_next;
    rwl_result_t      pend_reg;
    rwl_result_t      pend_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rwl_result_t      out_reg;
    rwl_result_t      out_next;

    // control from the sequencer's output decode
    logic             accept;
    logic             id_ok;
    logic             exec_act;
    logic             check_act;
    logic             drain_go;
    logic             query_kind;

    rwl_entry_t       head_entry;
    logic             q_wr_en;
    rwl_entry_t       q_wr_data;
    rwl_lock_op_t     lock_op;
    rwl_lock_status_t lock_status;

    // ids beyond the client count are dropped without any reply
    assign id_ok  = ({{(CMP_W-ID_W){1'b0}}, request.requester_id} < CMP_W'(CLIENT_COUNT));
    assign accept = start && (state_reg == ST_IDLE);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && id_ok)
                    state_next = ST_EXEC;
            end
            ST_EXEC:  state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (drain_go)
                    state_next = ST_READ;
                else
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        exec_act   = 1'b0;
        check_act  = 1'b0;
        busy       = 1'b1;
        query_kind = head_entry.kind;
        case (state_reg)
            ST_IDLE:  busy = 1'b0;
            ST_EXEC:
            begin
                exec_act   = 1'b1;
                query_kind = req_reg.requester_kind;
            end
            ST_READ:  check_act = 1'b0;
            ST_CHECK: check_act = 1'b1;
            default:  busy = 1'b0;
        endcase
    end

    // drain the head while it is compatible with the current holders
    assign drain_go = check_act && (fill_reg != '0) && lock_status.compatible;

    // ------------------------------------------------------------------
    // Request execution and drain datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        q_wr_en         = 1'b0;
        q_wr_data.kind  = req_reg.requester_kind;
        q_wr_data.id    = req_reg.requester_id;
        lock_op.take         = 1'b0;
        lock_op.release_hold = 1'b0;
        lock_op.kind         = query_kind;

        if (exec_act)
        begin
            pend_next.target_kind = req_reg.requester_kind;
            pend_next.target_id   = req_reg.requester_id;
            pend_next.last        = 1'b0;
            pend_next.reply_kind  = REPLY_GRANT;
            if (req_reg.action == ACT_LOCK)
            begin
                if ((fill_reg == '0) && lock_status.compatible)
                begin
                    // grant at once
                    lock_op.take    = 1'b1;
                    pend_valid_next = 1'b1;
                end
                else if (fill_reg < FW'(QUEUE_DEPTH))
                begin
                    // enqueue; no reply until drained
                    q_wr_en = 1'b1;
                    tail_next = (tail_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    pend_next.reply_kind = REPLY_FULL;
                    pend_valid_next      = 1'b1;
                end
            end
            else
            begin
                pend_valid_next = 1'b1;
                if (lock_status.held)
                begin
                    lock_op.release_hold = 1'b1;
                    pend_next.reply_kind = REPLY_ACK;
                end
                else
                begin
                    pend_next.reply_kind = REPLY_NO_HOLDER;
                end
            end
        end
        else if (drain_go)
        begin
            // hand out the head, flush the previous reply as not-last
            lock_op.take          = 1'b1;
            head_next = (head_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next             = fill_reg - 1'b1;
            out_valid_next        = pend_valid_reg;
            out_next              = pend_reg;
            out_next.last         = 1'b0;
            pend_valid_next       = 1'b1;
            pend_next.target_kind = head_entry.kind;
            pend_next.target_id   = head_entry.id;
            pend_next.reply_kind  = REPLY_GRANT;
            pend_next.last        = 1'b0;
        end
        else if (check_act)
        begin
            // drain done: the held reply is the final one
            out_valid_next  = pend_valid_reg;
            out_next        = pend_reg;
            out_next.last   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            req_reg <= request;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    rwl_wait_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_wait_mem (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (tail_reg),
        .wr_data (q_wr_data),
        .rd_addr (head_reg),
        .rd_data (head_entry)
    );

    rwl_lock_unit u_lock_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (lock_op),
        .query_kind (query_kind),
        .status     (lock_status)
    );

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (head_reg == tail_reg))
        else $error("empty queue with split pointers");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("reply strobed outside a request");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !pend_valid_reg)
        else $error("reply left pending while idle");
`endif

endmodule
`default_nettype wire

// File: rtl/core/rwl_wait_mem.sv
// Wait-queue storage: one write port, one registered read port.
`default_nettype none
module rwl_wait_mem
    import rwl_pkg::*;
#(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire rwl_entry_t    wr_data,
    input  wire logic [AW-1:0] rd_addr,
    output rwl_entry_t         rd_data
);

    rwl_entry_t mem [DEPTH];
    rwl_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: rtl/core/rwl_lock_unit.sv
// Lock state unit: reader count, writer flag, shared compatibility check.
`default_nettype none
module rwl_lock_unit
    import rwl_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire rwl_lock_op_t op,
    input  wire logic         query_kind,
    output rwl_lock_status_t  status
);

    logic [READERS_W-1:0] readers_reg;
    logic [READERS_W-1:0] readers_next;
    logic                 writer_reg;
    logic                 writer_next;

    // one compare unit serves both the incoming request and the queue head
    always_comb
    begin
        if (query_kind == KIND_WRITER)
        begin
            status.compatible = !writer_reg && (readers_reg == '0);
            status.held       = writer_reg;
        end
        else
        begin
            status.compatible = !writer_reg && (readers_reg < READERS_MAX);
            status.held       = (readers_reg != '0);
        end
    end

    always_comb
    begin
        readers_next = readers_reg;
        writer_next  = writer_reg;
        if (op.take)
        begin
            if (op.kind == KIND_WRITER)
                writer_next = 1'b1;
            else
                readers_next = readers_reg + 1'b1;
        end
        else if (op.release_hold)
        begin
            if (op.kind == KIND_WRITER)
                writer_next = 1'b0;
            else
                readers_next = readers_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            readers_reg <= '0;
            writer_reg  <= 1'b0;
        end
        else
        begin
            readers_reg <= readers_next;
            writer_reg  <= writer_next;
        end
    end

`ifndef SYNTH
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(writer_reg && (readers_reg != '0)))
        else $error("writer held alongside readers");

    a_take_compatible: assert property (@(posedge clk) disable iff (!rst_n)
        (op.take && (op.kind == query_kind)) |-> status.compatible)
        else $error("take issued on an incompatible lock");

    a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
        (op.release_hold && (op.kind == query_kind)) |-> status.held)
        else $error("release issued with no holder");
`endif

endmodule
`default_nettype wire
